// ===== rtl/core/tab_pkg.sv =====
// Shared constants, types and a saturation helper for the transformed AABB bounds block.
// No dependencies; compiled first.
package tab_pkg;

  localparam int COORD_W   = 32;  // signed Q16.16 coordinate
  localparam int SIZE_W    = 31;  // unsigned Q15.16 size
  localparam int COEF_W    = 16;  // signed Q4.12 coefficient
  localparam int COEF_FRAC = 12;
  localparam int AXES      = 3;
  localparam int ROW_W     = AXES * COEF_W;
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int RND_W     = PROD_W - COEF_FRAC;
  localparam int SUM_W     = RND_W + 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = ROW_W;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [SIZE_W-1:0]         SIZE_MAX  = {SIZE_W{1'b1}};

  // 1.0 in Q4.12
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = SUM_W'(COORD_MAX);
    lo_lim = SUM_W'(COORD_MIN);
    if (v > hi_lim) begin
      return COORD_MAX;
    end else if (v < lo_lim) begin
      return COORD_MIN;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/tab_box_if.sv =====
// Input channel carrying one axis-aligned box per transaction.
// Depends on tab_pkg for field widths.
interface tab_box_if import tab_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic [SIZE_W-1:0]         extent_x;
  logic [SIZE_W-1:0]         extent_y;
  logic [SIZE_W-1:0]         extent_z;

  modport source (output valid, origin_x, origin_y, origin_z, extent_x, extent_y, extent_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, extent_x, extent_y, extent_z,
                  output ready);
endinterface

// ===== rtl/core/tab_bound_if.sv =====
// Output channel carrying one enclosing box (minima and sizes) per transaction.
// Depends on tab_pkg for field widths.
interface tab_bound_if import tab_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] bound_min_x;
  logic signed [COORD_W-1:0] bound_min_y;
  logic signed [COORD_W-1:0] bound_min_z;
  logic [SIZE_W-1:0]         bound_size_x;
  logic [SIZE_W-1:0]         bound_size_y;
  logic [SIZE_W-1:0]         bound_size_z;

  modport source (output valid, bound_min_x, bound_min_y, bound_min_z,
                  bound_size_x, bound_size_y, bound_size_z, input ready);
  modport sink   (input valid, bound_min_x, bound_min_y, bound_min_z,
                  bound_size_x, bound_size_y, bound_size_z, output ready);
endinterface

// ===== rtl/core/transformed_aabb_bounds.sv =====
// Top level: affine-transformed axis-aligned bounding box, five-stage pipeline.
// Depends on tab_pkg, tab_box_if and tab_bound_if.
//
// Usage:
//   box_in carries one box (origin Q16.16, sizes Q15.16) per transaction; bound_out
//   carries the enclosing box of its eight transformed corners (minima and sizes).
//   The 3x3 Q4.12 matrix rows and the Q16.16 translation are set through the
//   write port (cfg_write, cfg_index, cfg_data); write them only while no box is
//   in flight. Indexes past the last register are ignored.
//   An accepted box passes stages 1 to 5 in order; stage 5 drives bound_out.
//   Throughput: one box per cycle unless bound_out.ready stalls; every stage holds one box and
//   eighteen 32x16 multipliers in the second stage set the pipeline depth.
//   The min and max over the eight corners are taken per matrix term: each term
//   picks the smaller and larger of its two rounded products, so no corner is
//   formed explicitly.
//   Reset (rst, synchronous) empties the pipeline and loads the identity
//   transform with zero translation.
//   When the receiver holds bound_out.ready low, the output stage holds its
//   transaction and the stages behind it fill up; box_in.ready drops only once
//   every stage is occupied. Nothing is lost or repeated.
module transformed_aabb_bounds import tab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  tab_box_if.sink              box_in,
  tab_bound_if.source          bound_out
);

  // configuration registers
  logic [ROW_W-1:0]          row   [AXES];
  logic signed [COORD_W-1:0] shift [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0]   <= ROW_W'(COEF_ONE);
      row[1]   <= ROW_W'(COEF_ONE) << COEF_W;
      row[2]   <= ROW_W'(COEF_ONE) << (2 * COEF_W);
      shift[0] <= '0;
      shift[1] <= '0;
      shift[2] <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_X:   row[0]   <= cfg_data;
        REG_ROW_Y:   row[1]   <= cfg_data;
        REG_ROW_Z:   row[2]   <= cfg_data;
        REG_SHIFT_X: shift[0] <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Y: shift[1] <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Z: shift[2] <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline valid bits and per-stage ready
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || bound_out.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign box_in.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= box_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: near and far corner coordinates per axis
  logic signed [COORD_W-1:0] org_in [AXES];
  logic [SIZE_W-1:0]         ext_in [AXES];
  logic signed [COORD_W-1:0] lo_s1  [AXES];
  logic signed [COORD_W-1:0] hi_s1  [AXES];
  logic signed [COORD_W-1:0] hi_next [AXES];

  assign org_in[0] = box_in.origin_x;
  assign org_in[1] = box_in.origin_y;
  assign org_in[2] = box_in.origin_z;
  assign ext_in[0] = box_in.extent_x;
  assign ext_in[1] = box_in.extent_y;
  assign ext_in[2] = box_in.extent_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      hi_next[a] = sat_coord(SUM_W'(org_in[a]) + SUM_W'({1'b0, ext_in[a]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && box_in.valid) begin
      lo_s1 <= org_in;
      hi_s1 <= hi_next;
    end
  end

  // stage 2: products of both corner values with every coefficient
  logic signed [PROD_W-1:0] plo_s2 [AXES][AXES];
  logic signed [PROD_W-1:0] phi_s2 [AXES][AXES];

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int r = 0; r < AXES; r++) begin
        for (int k = 0; k < AXES; k++) begin
          plo_s2[r][k] <= PROD_W'(lo_s1[k] * $signed(row[r][k*COEF_W +: COEF_W]));
          phi_s2[r][k] <= PROD_W'(hi_s1[k] * $signed(row[r][k*COEF_W +: COEF_W]));
        end
      end
    end
  end

  // stage 3: round to Q16.16, keep smaller and larger term
  logic signed [RND_W-1:0] rlo [AXES][AXES];
  logic signed [RND_W-1:0] rhi [AXES][AXES];
  logic signed [RND_W-1:0] tmin_s3 [AXES][AXES];
  logic signed [RND_W-1:0] tmax_s3 [AXES][AXES];
  logic signed [PROD_W-1:0] sum_lo;
  logic signed [PROD_W-1:0] sum_hi;

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      for (int k = 0; k < AXES; k++) begin
        sum_lo = plo_s2[r][k] + PROD_W'(1 << (COEF_FRAC - 1));
        sum_hi = phi_s2[r][k] + PROD_W'(1 << (COEF_FRAC - 1));
        rlo[r][k] = sum_lo[PROD_W-1:COEF_FRAC];
        rhi[r][k] = sum_hi[PROD_W-1:COEF_FRAC];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int r = 0; r < AXES; r++) begin
        for (int k = 0; k < AXES; k++) begin
          if (rlo[r][k] < rhi[r][k]) begin
            tmin_s3[r][k] <= rlo[r][k];
            tmax_s3[r][k] <= rhi[r][k];
          end else begin
            tmin_s3[r][k] <= rhi[r][k];
            tmax_s3[r][k] <= rlo[r][k];
          end
        end
      end
    end
  end

  // stage 4: sum terms plus translation, saturate
  logic signed [COORD_W-1:0] mn_s4 [AXES];
  logic signed [COORD_W-1:0] mx_s4 [AXES];

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      for (int r = 0; r < AXES; r++) begin
        mn_s4[r] <= sat_coord(SUM_W'(tmin_s3[r][0]) + SUM_W'(tmin_s3[r][1])
                              + SUM_W'(tmin_s3[r][2]) + SUM_W'(shift[r]));
        mx_s4[r] <= sat_coord(SUM_W'(tmax_s3[r][0]) + SUM_W'(tmax_s3[r][1])
                              + SUM_W'(tmax_s3[r][2]) + SUM_W'(shift[r]));
      end
    end
  end

  // stage 5: sizes, output register
  logic [COORD_W:0]          diff [AXES];
  logic [SIZE_W-1:0]         size_next [AXES];
  logic signed [COORD_W-1:0] mn_s5 [AXES];
  logic [SIZE_W-1:0]         size_s5 [AXES];

  always_comb begin
    for (int r = 0; r < AXES; r++) begin
      diff[r] = (COORD_W+1)'(mx_s4[r]) - (COORD_W+1)'(mn_s4[r]);
      // max is never below min, so only the upper end can overflow
      size_next[r] = (diff[r][COORD_W:SIZE_W] != '0) ? SIZE_MAX : diff[r][SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      mn_s5   <= mn_s4;
      size_s5 <= size_next;
    end
  end

  assign bound_out.valid        = v5;
  assign bound_out.bound_min_x  = mn_s5[0];
  assign bound_out.bound_min_y  = mn_s5[1];
  assign bound_out.bound_min_z  = mn_s5[2];
  assign bound_out.bound_size_x = size_s5[0];
  assign bound_out.bound_size_y = size_s5[1];
  assign bound_out.bound_size_z = size_s5[2];

`ifndef SYNTHESIS
  a_far_not_below_near: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (hi_s1[0] >= lo_s1[0]) && (hi_s1[1] >= lo_s1[1]) && (hi_s1[2] >= lo_s1[2]))
    else $error("far corner below near corner");

  a_max_not_below_min: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (mx_s4[0] >= mn_s4[0]) && (mx_s4[1] >= mn_s4[1]) && (mx_s4[2] >= mn_s4[2]))
    else $error("bound maximum below minimum");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !v1 && !v2 && !v3 && !v4 && !v5)
    else $error("pipeline not empty after reset");

  a_stall_holds_stage4: assert property (@(posedge clk) disable iff (rst)
    (v4 && !rdy4) |=> v4 && $stable(mn_s4[0]) && $stable(mx_s4[0]))
    else $error("stalled stage lost its transaction");
`endif

endmodule

// ===== dv/transformed_aabb_bounds_checker.sv =====
// Checker for the transformed AABB bounds block: predicts each enclosing box and compares it.
// Watches the write port and both channels; depends on tab_pkg, tab_box_if and tab_bound_if.
module transformed_aabb_bounds_checker import tab_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  tab_box_if                   box_in,
  tab_bound_if                 bound_out,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] lo;
    logic [AXES-1:0][SIZE_W-1:0]  size;
  } bound_t;

  // Shadow copy of the transform registers
  logic [ROW_W-1:0]          coef_rows   [AXES];
  logic signed [COORD_W-1:0] shift_regs  [AXES];

  bound_t awaited_bounds [$];
  int     mismatches = 0;
  int     reports    = 0;

  function automatic longint clamp_coord(input longint v);
    longint hi_lim;
    longint lo_lim;
    hi_lim = longint'(COORD_MAX);
    lo_lim = longint'(COORD_MIN);
    if (v > hi_lim) return hi_lim;
    if (v < lo_lim) return lo_lim;
    return v;
  endfunction

  // Round a Q.28 product to Q16.16: add half an LSB, then floor
  function automatic longint round_q28(input longint v);
    return (v + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic longint transform_axis(input logic [ROW_W-1:0] row,
                                            input logic signed [COORD_W-1:0] shift,
                                            input longint p [AXES]);
    longint acc;
    longint c;
    acc = longint'(shift);
    for (int k = 0; k < AXES; k++) begin
      c   = longint'($signed(row[COEF_W*k +: COEF_W]));
      acc = acc + round_q28(p[k] * c);
    end
    return clamp_coord(acc);
  endfunction

  function automatic bound_t enclose_transformed_box(
      input logic [AXES-1:0][COORD_W-1:0] org,
      input logic [AXES-1:0][SIZE_W-1:0]  ext);
    longint lo     [AXES];
    longint hi     [AXES];
    longint corner [AXES];
    longint mn     [AXES];
    longint mx     [AXES];
    longint t;
    longint span;
    bound_t r;
    for (int a = 0; a < AXES; a++) begin
      lo[a] = longint'($signed(org[a]));
      hi[a] = clamp_coord(lo[a] + longint'(ext[a]));
    end
    for (int c = 0; c < 8; c++) begin
      for (int a = 0; a < AXES; a++) corner[a] = ((c >> a) & 1) ? hi[a] : lo[a];
      for (int a = 0; a < AXES; a++) begin
        t = transform_axis(coef_rows[a], shift_regs[a], corner);
        if (c == 0 || t < mn[a]) mn[a] = t;
        if (c == 0 || t > mx[a]) mx[a] = t;
      end
    end
    for (int a = 0; a < AXES; a++) begin
      span = mx[a] - mn[a];
      if (span > longint'(SIZE_MAX)) span = longint'(SIZE_MAX);
      r.lo[a]   = COORD_W'(mn[a]);
      r.size[a] = SIZE_W'(span);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    bound_t want;
    bound_t got;
    if (rst) begin
      coef_rows[0]  = ROW_W'(COEF_ONE);
      coef_rows[1]  = ROW_W'(COEF_ONE) << COEF_W;
      coef_rows[2]  = ROW_W'(COEF_ONE) << (2 * COEF_W);
      for (int a = 0; a < AXES; a++) shift_regs[a] = '0;
      awaited_bounds.delete();
    end else begin
      if (box_in.valid && box_in.ready) begin
        // append at the tail so bounds come back in order
        awaited_bounds.insert(awaited_bounds.size(), enclose_transformed_box(
          {box_in.origin_z, box_in.origin_y, box_in.origin_x},
          {box_in.extent_z, box_in.extent_y, box_in.extent_x}));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_X:   coef_rows[0]  = cfg_data[ROW_W-1:0];
          REG_ROW_Y:   coef_rows[1]  = cfg_data[ROW_W-1:0];
          REG_ROW_Z:   coef_rows[2]  = cfg_data[ROW_W-1:0];
          REG_SHIFT_X: shift_regs[0] = cfg_data[COORD_W-1:0];
          REG_SHIFT_Y: shift_regs[1] = cfg_data[COORD_W-1:0];
          REG_SHIFT_Z: shift_regs[2] = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (bound_out.valid && bound_out.ready) begin
        got.lo   = {bound_out.bound_min_z, bound_out.bound_min_y, bound_out.bound_min_x};
        got.size = {bound_out.bound_size_z, bound_out.bound_size_y, bound_out.bound_size_x};
        if (awaited_bounds.size() == 0) begin
          mismatches++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: unexpected bound transaction, min %0d %0d %0d", $time,
                     $signed(got.lo[0]), $signed(got.lo[1]), $signed(got.lo[2]));
          end
        end else begin
          want = awaited_bounds.pop_front();
          for (int a = 0; a < AXES; a++) begin
            if (got.lo[a] !== want.lo[a]) begin
              mismatches++;
              if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: bound_min axis %0d expected %0d actual %0d", $time, a,
                         $signed(want.lo[a]), $signed(got.lo[a]));
              end
            end
            if (got.size[a] !== want.size[a]) begin
              mismatches++;
              if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t: bound_size axis %0d expected %0d actual %0d", $time, a,
                         want.size[a], got.size[a]);
              end
            end
          end
        end
      end
    end
    pending    <= awaited_bounds.size();
    fail_count <= mismatches;
  end

endmodule

// ===== dv/transformed_aabb_bounds_tb.sv =====
// Testbench top for transformed_aabb_bounds: clock, reset, box stimulus, register writes, verdict.
// Depends on tab_pkg, the channel interfaces, the block and transformed_aabb_bounds_checker.
module transformed_aabb_bounds_tb import tab_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1100;
  localparam int RANDOM_PHASES = 9;
  localparam int STALL_PHASE   = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LIMIT_CYCLES  = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED     = CFG_IDX_W'(REG_SHIFT_Z) + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = '1;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit stall_req    = 1'b0;
  bit stall_done   = 1'b0;
  int boxes_sent   = 0;
  int settings_loaded = 1;
  int cycle_count  = 0;

  tab_box_if   box_ch ();
  tab_bound_if bound_ch ();

  transformed_aabb_bounds u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box_in    (box_ch),
    .bound_out (bound_ch)
  );

  transformed_aabb_bounds_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .box_in     (box_ch),
    .bound_out  (bound_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when requested
  initial begin
    bound_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req && !stall_done) begin
        bound_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_done = 1'b1;
      end else begin
        bound_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  task automatic send_box(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                          input logic [COORD_W-1:0] oz, input logic [SIZE_W-1:0] ex,
                          input logic [SIZE_W-1:0] ey, input logic [SIZE_W-1:0] ez);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(posedge clk);
    end
    box_ch.valid    <= 1'b1;
    box_ch.origin_x <= ox;
    box_ch.origin_y <= oy;
    box_ch.origin_z <= oz;
    box_ch.extent_x <= ex;
    box_ch.extent_y <= ey;
    box_ch.extent_z <= ez;
    do @(posedge clk); while (!box_ch.ready);
    boxes_sent++;
  endtask

  // Drop valid and wait until every expected bound has come back
  task automatic drain_pipeline();
    box_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_transform(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                                 input logic [ROW_W-1:0] rz, input logic [COORD_W-1:0] sx,
                                 input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] sz);
    logic [CFG_IDX_W-1:0] idx [8];
    logic [CFG_W-1:0]     val [8];
    idx[0] = REG_ROW_X;        val[0] = CFG_W'(rx);
    idx[1] = REG_ROW_Y;        val[1] = CFG_W'(ry);
    idx[2] = REG_ROW_Z;        val[2] = CFG_W'(rz);
    idx[3] = REG_SHIFT_X;      val[3] = CFG_W'(sx);
    idx[4] = REG_SHIFT_Y;      val[4] = CFG_W'(sy);
    idx[5] = REG_SHIFT_Z;      val[5] = CFG_W'(sz);
    // writes past the last register must leave the transform alone
    idx[6] = REG_UNMAPPED;     val[6] = CFG_W'({$urandom(), $urandom()});
    idx[7] = REG_UNMAPPED_TOP; val[7] = CFG_W'({$urandom(), $urandom()});
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [ROW_W-1:0] random_row(input int style, input int axis);
    logic [ROW_W-1:0] r;
    case (style)
      0: r = ROW_W'({$urandom(), $urandom()});
      1: begin
        for (int k = 0; k < AXES; k++)
          r[COEF_W*k +: COEF_W] = COEF_W'($urandom_range(0, 16383) - 8192);
      end
      default: begin
        // signed axis permutation
        r = '0;
        r[COEF_W*((axis + style) % AXES) +: COEF_W] =
          $urandom_range(0, 1) ? COEF_ONE : -COEF_ONE;
      end
    endcase
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] random_shift(input int style);
    if (style == 0) return COORD_W'($urandom());
    return COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
  endfunction

  task automatic send_directed(input int i);
    case (i)
      0: send_box('0, '0, '0, '0, '0, '0);
      // far corner overflows at every axis
      1: send_box(COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX);
      2: send_box(COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX);
      3: send_box(COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0);
      // odd coordinates: half-LSB ties under the half-weight matrix
      4: send_box('1, -COORD_W'(3), COORD_W'(1), SIZE_W'(1), SIZE_W'(2), SIZE_W'(1));
      default: send_box(COORD_MAX, COORD_MIN, '0, SIZE_MAX, '0, SIZE_W'(1));
    endcase
  endtask

  task automatic send_random_box();
    int r;
    logic [COORD_W-1:0] o [AXES];
    logic [SIZE_W-1:0]  e [AXES];
    r = $urandom_range(0, 99);
    for (int a = 0; a < AXES; a++) begin
      if (r < 50) begin
        o[a] = COORD_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        e[a] = SIZE_W'($urandom_range(0, 1 << 22));
      end else if (r < 60) begin
        o[a] = COORD_W'($urandom());
        e[a] = '0;
      end else begin
        o[a] = COORD_W'($urandom());
        e[a] = SIZE_W'($urandom());
      end
    end
    send_box(o[0], o[1], o[2], e[0], e[1], e[2]);
  endtask

  initial begin
    int style;
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    box_ch.valid    <= 1'b0;
    box_ch.origin_x <= '0;
    box_ch.origin_y <= '0;
    box_ch.origin_z <= '0;
    box_ch.extent_x <= '0;
    box_ch.extent_y <= '0;
    box_ch.extent_z <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(19, 55);
    // Directed: identity after reset, largest and smallest coefficients, half weights
    for (int cfg = 0; cfg < 4; cfg++) begin
      case (cfg)
        1: apply_transform({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
                           COORD_MAX, COORD_MAX, COORD_MAX);
        2: apply_transform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                           COORD_MIN, COORD_MIN, COORD_MIN);
        3: apply_transform({16'hf800, 16'h0800, 16'h0800}, {16'h0800, 16'hf800, 16'h0800},
                           {16'h0800, 16'h0800, 16'hf800},
                           COORD_W'(1), -COORD_W'(1), COORD_W'(3));
        default: ;
      endcase
      for (int i = 0; i < 6; i++) send_directed(i);
      drain_pipeline();
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 3) set_idling(19, 55);
      else if (p < 6) set_idling(55, 19);
      else set_idling(0, 0);
      style = p % 3;
      apply_transform(random_row(style, 0), random_row(style, 1), random_row(style, 2),
                      random_shift(style), random_shift(style), random_shift(style));
      if (p == STALL_PHASE) stall_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) send_random_box();
      drain_pipeline();
    end

    $display("Covered %0d boxes over %0d transform settings: identity, saturating extremes,",
             boxes_sent, settings_loaded);
    $display("rounding ties, random matrices; alternating idling and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tab_pkg.sv
rtl/core/tab_box_if.sv
rtl/core/tab_bound_if.sv
rtl/core/transformed_aabb_bounds.sv
dv/transformed_aabb_bounds_checker.sv
dv/transformed_aabb_bounds_tb.sv
